[rtl/dwpw_pkg.sv]
// Shared types and constants for the display window pixel writer.
// No dependencies; every other file refers to this package by scoped names.
package dwpw_pkg;

    localparam int COORD_W   = 16;
    localparam int SCREEN_W  = 11;
    localparam int COLOR_W   = 16;
    localparam int COUNT_W   = 21;
    localparam int PROD_W    = 2 * SCREEN_W;
    localparam int BURST_MAX = 11;
    localparam int BURST_LEN_W = $clog2(BURST_MAX + 1);
    localparam int IN_TDATA_W  = 88;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;
    localparam logic [7:0] BYTE_MASK      = 8'hFF;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 11'd480;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 11'd320;

    // Register indexes, selected by paddr[2]
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // Request kinds
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] region_width;
        logic [COORD_W-1:0] region_height;
        logic               fill_mode;
        logic [COLOR_W-1:0] color;
    } item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
    } bus_word_t;

    typedef struct packed {
        logic                                valid;
        logic [BURST_LEN_W-1:0]              len;
        bus_word_t [BURST_MAX-1:0]           words;
    } burst_t;

endpackage

[rtl/display_window_pixel_writer.sv]
// Top level of the display window pixel writer: request register, region
// logic, burst serializer and APB registers. Depends on dwpw_pkg and submodules.
//
//  channel   | role                       | fields
//  ----------+----------------------------+------------------------------------
//  s_axis    | request in                 | tuser: func; tdata: start_x,
//            |                            | start_y, region_width, region_height,
//            |                            | fill_mode, color
//  m_axis    | bus byte out               | tdata: bus_byte; tuser: is_data;
//            |                            | tlast: last byte of a request
//  apb       | screen_width, screen_height| 0x0 width, 0x4 height
//
// A request is held in one input register; the region logic turns it into a
// burst that the serializer loads once it is free, and the serializer sends
// one byte per cycle while m_axis_tready is high. A start yields eleven bytes,
// an advance two. A new request enters while the previous burst drains; the
// held request moves on as the last byte of the current burst is taken.
// Requests that produce no bytes leave the register without output. Reset
// clears the open region, restores 480 x 320 and empties both stages.
module display_window_pixel_writer
(
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] start_x, [31:16] start_y, [47:32] region_width,
    // [63:48] region_height, [64] fill_mode, [80:65] color, [87:81] zero
    input  logic [dwpw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] func
    input  logic                                s_axis_tuser,
    // bus byte channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] bus_byte
    output logic [7:0]                          m_axis_tdata,
    // [0] is_data
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dwpw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dwpw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dwpw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    dwpw_pkg::item_t               in_item_reg;
    dwpw_pkg::item_t               in_item_next;
    logic                          take;
    logic                          burst_free;
    dwpw_pkg::burst_t              burst;
    logic [dwpw_pkg::SCREEN_W-1:0] screen_width;
    logic [dwpw_pkg::SCREEN_W-1:0] screen_height;

    // Accept a request when the holding register is empty or is being drained.
    assign s_axis_tready = ~in_valid_reg | take;

    always_comb
    begin
        in_valid_next = in_valid_reg & ~take;
        in_item_next  = in_item_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next              = 1'b1;
            in_item_next.func          = s_axis_tuser;
            in_item_next.start_x       = s_axis_tdata[15:0];
            in_item_next.start_y       = s_axis_tdata[31:16];
            in_item_next.region_width  = s_axis_tdata[47:32];
            in_item_next.region_height = s_axis_tdata[63:48];
            in_item_next.fill_mode     = s_axis_tdata[64];
            in_item_next.color         = s_axis_tdata[80:65];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    dwpw_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .screen_width  (screen_width),
        .screen_height (screen_height)
    );

    dwpw_window u_window
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_valid_reg),
        .item          (in_item_reg),
        .screen_width  (screen_width),
        .screen_height (screen_height),
        .burst_free    (burst_free),
        .take          (take),
        .burst         (burst)
    );

    dwpw_burst u_burst
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .burst_free  (burst_free),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_is_data (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

endmodule

[rtl/dwpw_regs.sv]
// APB register file: screen width and height used for clipping.
// Depends on dwpw_pkg.
module dwpw_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dwpw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dwpw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dwpw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [dwpw_pkg::SCREEN_W-1:0]      screen_width,
    output logic [dwpw_pkg::SCREEN_W-1:0]      screen_height
);

    logic [dwpw_pkg::SCREEN_W-1:0] screen_width_reg;
    logic [dwpw_pkg::SCREEN_W-1:0] screen_height_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= dwpw_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg <= dwpw_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                dwpw_pkg::REG_SCREEN_WIDTH:
                    screen_width_reg  <= pwdata[dwpw_pkg::SCREEN_W-1:0];
                dwpw_pkg::REG_SCREEN_HEIGHT:
                    screen_height_reg <= pwdata[dwpw_pkg::SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            dwpw_pkg::REG_SCREEN_WIDTH:
                prdata[dwpw_pkg::SCREEN_W-1:0] = screen_width_reg;
            dwpw_pkg::REG_SCREEN_HEIGHT:
                prdata[dwpw_pkg::SCREEN_W-1:0] = screen_height_reg;
            default: prdata = '0;
        endcase
    end

    assign screen_width  = screen_width_reg;
    assign screen_height = screen_height_reg;

endmodule

[rtl/dwpw_window.sv]
// Region state and burst builder: clips a start request, forms the command
// burst and pixel bursts, and keeps the open region. Depends on dwpw_pkg.
module dwpw_window
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  dwpw_pkg::item_t                 item,
    input  logic [dwpw_pkg::SCREEN_W-1:0]   screen_width,
    input  logic [dwpw_pkg::SCREEN_W-1:0]   screen_height,
    input  logic                            burst_free,
    output logic                            take,
    output dwpw_pkg::burst_t                burst
);

    logic [dwpw_pkg::COUNT_W-1:0] pixels_left_reg;
    logic [dwpw_pkg::COUNT_W-1:0] pixels_left_next;
    logic                         fill_mode_reg;
    logic                         fill_mode_next;
    logic [dwpw_pkg::COLOR_W-1:0] color_reg;
    logic [dwpw_pkg::COLOR_W-1:0] color_next;

    logic                          off_screen;
    logic [dwpw_pkg::COORD_W:0]    sum_x;
    logic [dwpw_pkg::COORD_W:0]    sum_y;
    logic [dwpw_pkg::SCREEN_W-1:0] width_clip;
    logic [dwpw_pkg::SCREEN_W-1:0] height_clip;
    logic [dwpw_pkg::COORD_W-1:0]  end_x;
    logic [dwpw_pkg::COORD_W-1:0]  end_y;
    logic [dwpw_pkg::PROD_W-1:0]   area;
    logic [dwpw_pkg::COUNT_W-1:0]  area_sat;
    logic [dwpw_pkg::COLOR_W-1:0]  pixel;
    logic                          is_start;

    assign take     = item_valid & burst_free;
    assign is_start = (item.func == dwpw_pkg::FUNC_START);

    // Clip to the panel; a start at or past the edge is dropped.
    always_comb
    begin
        off_screen = (item.start_x >= {5'd0, screen_width}) |
                     (item.start_y >= {5'd0, screen_height});
        sum_x = {1'b0, item.start_x} + {1'b0, item.region_width};
        sum_y = {1'b0, item.start_y} + {1'b0, item.region_height};

        if (item.region_width == '0)
            width_clip = '0;
        else if (sum_x > {6'd0, screen_width})
            width_clip = screen_width - item.start_x[dwpw_pkg::SCREEN_W-1:0];
        else
            width_clip = item.region_width[dwpw_pkg::SCREEN_W-1:0];

        if (item.region_height == '0)
            height_clip = '0;
        else if (sum_y > {6'd0, screen_height})
            height_clip = screen_height - item.start_y[dwpw_pkg::SCREEN_W-1:0];
        else
            height_clip = item.region_height[dwpw_pkg::SCREEN_W-1:0];

        end_x = item.start_x + {5'd0, width_clip} - 16'd1;
        end_y = item.start_y + {5'd0, height_clip} - 16'd1;

        area     = {{dwpw_pkg::SCREEN_W{1'b0}}, width_clip} *
                   {{dwpw_pkg::SCREEN_W{1'b0}}, height_clip};
        area_sat = (area > {1'b0, dwpw_pkg::COUNT_MAX}) ? dwpw_pkg::COUNT_MAX
                                                         : area[dwpw_pkg::COUNT_W-1:0];

        pixel = fill_mode_reg ? color_reg : item.color;
    end

    // Build the burst handed to the serializer, first byte at index 0.
    // Hand it over only when the serializer takes the request.
    always_comb
    begin
        burst       = '0;
        burst.valid = 1'b0;
        if (is_start)
        begin
            burst.valid    = take & ~off_screen;
            burst.len      = dwpw_pkg::BURST_LEN_W'(dwpw_pkg::BURST_MAX);
            burst.words[0] = '{is_data: 1'b0, value: dwpw_pkg::CMD_COLUMN_SET};
            burst.words[1] = '{is_data: 1'b1, value: item.start_x[15:8]};
            burst.words[2] = '{is_data: 1'b1, value: item.start_x[7:0] & dwpw_pkg::BYTE_MASK};
            burst.words[3] = '{is_data: 1'b1, value: end_x[15:8]};
            burst.words[4] = '{is_data: 1'b1, value: end_x[7:0]};
            burst.words[5] = '{is_data: 1'b0, value: dwpw_pkg::CMD_PAGE_SET};
            burst.words[6] = '{is_data: 1'b1, value: item.start_y[15:8]};
            burst.words[7] = '{is_data: 1'b1, value: item.start_y[7:0]};
            burst.words[8] = '{is_data: 1'b1, value: end_y[15:8]};
            burst.words[9] = '{is_data: 1'b1, value: end_y[7:0]};
            burst.words[10] = '{is_data: 1'b0, value: dwpw_pkg::CMD_MEM_WRITE};
        end
        else
        begin
            burst.valid    = take & (pixels_left_reg != '0);
            burst.len      = dwpw_pkg::BURST_LEN_W'(2);
            burst.words[0] = '{is_data: 1'b1, value: pixel[15:8]};
            burst.words[1] = '{is_data: 1'b1, value: pixel[7:0]};
        end
    end

    always_comb
    begin
        pixels_left_next = pixels_left_reg;
        fill_mode_next   = fill_mode_reg;
        color_next       = color_reg;
        if (take)
        begin
            if (is_start)
            begin
                if (off_screen)
                    pixels_left_next = '0;
                else
                begin
                    pixels_left_next = area_sat;
                    fill_mode_next   = item.fill_mode;
                    color_next       = item.color;
                end
            end
            else if (pixels_left_reg != '0)
                pixels_left_next = pixels_left_reg - dwpw_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_left_reg <= '0;
            fill_mode_reg   <= 1'b0;
            color_reg       <= '0;
        end
        else
        begin
            pixels_left_reg <= pixels_left_next;
            fill_mode_reg   <= fill_mode_next;
            color_reg       <= color_next;
        end
    end

endmodule

[rtl/dwpw_burst.sv]
// Burst serializer: holds up to eleven bus words and shifts one out per
// accepted output request. Depends on dwpw_pkg.
module dwpw_burst
(
    input  logic             clk,
    input  logic             rst_n,
    input  dwpw_pkg::burst_t burst,
    output logic             burst_free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_is_data,
    output logic             out_last
);

    dwpw_pkg::bus_word_t [dwpw_pkg::BURST_MAX-1:0] words_reg;
    dwpw_pkg::bus_word_t [dwpw_pkg::BURST_MAX-1:0] words_next;
    logic [dwpw_pkg::BURST_LEN_W-1:0]              cnt_reg;
    logic [dwpw_pkg::BURST_LEN_W-1:0]              cnt_next;
    logic                                          out_fire;

    assign out_valid  = (cnt_reg != '0);
    assign out_fire   = out_valid & out_ready;
    assign burst_free = ~out_valid | (out_fire & (cnt_reg == dwpw_pkg::BURST_LEN_W'(1)));

    assign out_byte    = words_reg[0].value;
    assign out_is_data = words_reg[0].is_data;
    assign out_last    = (cnt_reg == dwpw_pkg::BURST_LEN_W'(1));

    always_comb
    begin
        words_next = words_reg;
        cnt_next   = cnt_reg;
        if (burst.valid)
        begin
            words_next = burst.words;
            cnt_next   = burst.len;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < dwpw_pkg::BURST_MAX - 1; i++)
                words_next[i] = words_reg[i+1];
            words_next[dwpw_pkg::BURST_MAX-1] = '0;
            cnt_next = cnt_reg - dwpw_pkg::BURST_LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

endmodule
